### rtl/mclm_pkg.sv
// Package for the multi-channel liveness monitor.
// Holds the channel count, command and register codes, item types and reset values.
// No dependencies; every other file imports it.
`default_nettype none

package mclm_pkg;

    localparam int CHANNELS = 8;

    localparam int TIME_W  = 32;
    localparam int CHAN_W  = 3;
    localparam int MASK_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] LIMITS_RESET   = 64'h3232_3228_2828_2832;
    localparam logic [CFG_W-1:0] HOLDOFFS_RESET = 64'h0;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_LIMITS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_HOLDOFFS = 1'd1;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_HEARD  = 2'd1,
        CMD_ENABLE = 2'd2,
        CMD_SCAN   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [CHAN_W-1:0] channel;
        logic              enable_value;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] lost_mask;
        logic [TIME_W-1:0] channel_lost_time;
    } out_item_t;

    // Per-cell strobes from the controller.
    typedef struct packed {
        logic heard;
        logic en_we;
        logic en_val;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/mclm_cell.sv
// One channel cell of the liveness monitor chain.
// Holds the channel's time stamps, lost and enable flags, and passes the scan token on.
// Depends on mclm_pkg.
`default_nettype none

module mclm_cell (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  mclm_pkg::cell_ctrl_t        ctrl,
    input  wire [mclm_pkg::TIME_W-1:0]  now,
    input  wire [mclm_pkg::BYTE_W-1:0]  limit,
    input  wire [mclm_pkg::BYTE_W-1:0]  holdoff,
    input  wire                         tok_in,
    output logic                        tok_out,
    output logic                        lost,
    output logic [mclm_pkg::TIME_W-1:0] loss_time
);
    import mclm_pkg::*;

    logic [TIME_W-1:0] last_heard_reg, last_heard_next;
    logic [TIME_W-1:0] online_since_reg, online_since_next;
    logic [TIME_W-1:0] loss_time_reg, loss_time_next;
    logic              lost_reg, lost_next;
    logic              enable_reg, enable_next;
    logic              tok_reg;
    logic [TIME_W-1:0] since_online;
    logic [TIME_W-1:0] silence;

    assign since_online = now - online_since_reg;
    assign silence      = now - last_heard_reg;

    always_comb begin
        last_heard_next   = last_heard_reg;
        online_since_next = online_since_reg;
        loss_time_next    = loss_time_reg;
        lost_next         = lost_reg;
        enable_next       = enable_reg;
        if (ctrl.heard) begin
            last_heard_next = now;
            if (lost_reg) begin
                lost_next         = 1'b0;
                online_since_next = now;
            end
        end
        if (ctrl.en_we) begin
            enable_next = ctrl.en_val;
        end
        // The token reaches this cell once per scan; a disabled channel lets it pass untouched.
        if (tok_in && enable_reg) begin
            priority if (since_online < {{(TIME_W-BYTE_W){1'b0}}, holdoff}) begin
                lost_next = 1'b0;
            end else if (silence > {{(TIME_W-BYTE_W){1'b0}}, limit}) begin
                if (!lost_reg) begin
                    lost_next      = 1'b1;
                    loss_time_next = now;
                end
            end else begin
                lost_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_heard_reg   <= '0;
            online_since_reg <= '0;
            loss_time_reg    <= '0;
            lost_reg         <= 1'b1;
            enable_reg       <= 1'b1;
            tok_reg          <= 1'b0;
        end else begin
            last_heard_reg   <= last_heard_next;
            online_since_reg <= online_since_next;
            loss_time_reg    <= loss_time_next;
            lost_reg         <= lost_next;
            enable_reg       <= enable_next;
            tok_reg          <= tok_in;
        end
    end

    assign tok_out   = tok_reg;
    assign lost      = lost_reg;
    assign loss_time = loss_time_reg;

endmodule

`default_nettype wire

### rtl/multi_channel_liveness_monitor.sv
// Top level of the multi-channel liveness monitor: controller, tick counter,
// configuration registers, output register and the chain of channel cells.
// Depends on mclm_pkg and mclm_cell.
`default_nettype none

// Tick, heard and set-enable items first update the cells and then load the
// result register. A scan item sends a token along the row of channel cells,
// each cell checking its own channel in the cycle that it holds the token, and
// loads the result register once the token has left the last cell. A new item
// is taken while the previous result still waits in the output register; the
// next result is held back until that one has been collected. Configuration
// writes are always accepted and should only be issued while the block is idle.
module multi_channel_liveness_monitor (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  mclm_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output mclm_pkg::out_item_t               m_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [mclm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [mclm_pkg::CFG_W-1:0]         cfg_data
);
    import mclm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CFG_W-1:0]  limits_reg, limits_next;
    logic [CFG_W-1:0]  holdoffs_reg, holdoffs_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              accept;
    logic [CHANNELS:0] tok;
    logic [CHANNELS-1:0] lost_vec;
    logic [TIME_W-1:0] loss_vec [CHANNELS];
    cell_ctrl_t        ctrl_vec [CHANNELS];
    logic [MASK_W-1:0] mask_now;
    logic [TIME_W-1:0] sel_loss;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign tok[0]    = accept && (s_data.command == CMD_SCAN);

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
            always_comb begin
                ctrl_vec[gi].heard  = accept && (s_data.command == CMD_HEARD)
                                      && (s_data.channel == CHAN_W'(gi));
                ctrl_vec[gi].en_we  = accept && (s_data.command == CMD_ENABLE)
                                      && (s_data.channel == CHAN_W'(gi));
                ctrl_vec[gi].en_val = s_data.enable_value;
            end

            mclm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl_vec[gi]),
                .now       (now_reg),
                .limit     (limits_reg[BYTE_W*gi +: BYTE_W]),
                .holdoff   (holdoffs_reg[BYTE_W*gi +: BYTE_W]),
                .tok_in    (tok[gi]),
                .tok_out   (tok[gi+1]),
                .lost      (lost_vec[gi]),
                .loss_time (loss_vec[gi])
            );
        end
    endgenerate

    // Builds the lost mask from every cell and picks the named channel's loss time (zero if no cell matches).
    always_comb begin
        mask_now = '0;
        sel_loss = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            mask_now[i] = lost_vec[i];
            if (chan_reg == CHAN_W'(i)) begin
                sel_loss = loss_vec[i];
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        limits_next   = limits_reg;
        holdoffs_next = holdoffs_reg;
        chan_next     = chan_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OFFLINE_LIMITS:  limits_next   = cfg_data;
                CFG_ONLINE_HOLDOFFS: holdoffs_next = cfg_data;
                default:             limits_next   = limits_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    chan_next = s_data.channel;
                    if (s_data.command == CMD_TICK) begin
                        now_next = now_reg + TIME_W'(1);
                    end
                    state_next = (s_data.command == CMD_SCAN) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (tok[CHANNELS]) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                  = 1'b1;
                    m_data_next.lost_mask         = mask_now;
                    m_data_next.channel_lost_time = sel_loss;
                    state_next                    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            limits_reg   <= LIMITS_RESET;
            holdoffs_reg <= HOLDOFFS_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            limits_reg   <= limits_next;
            holdoffs_reg <= holdoffs_next;
            m_valid_reg  <= m_valid_next;
        end
        chan_reg   <= chan_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the multi-channel liveness monitor.
// Holds its own prediction of the lost flags and loss times, drives directed and random items.
// Depends on mclm_pkg and multi_channel_liveness_monitor.
`default_nettype none

module testbench;
    import mclm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = CHANNELS + 8;
    localparam int IDLE_PERCENT = 26;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // Predicted state of the monitor.
    logic [CFG_W-1:0]  limit_reg = LIMITS_RESET;
    logic [CFG_W-1:0]  holdoff_reg = HOLDOFFS_RESET;
    logic [TIME_W-1:0] tick_now = '0;
    logic [TIME_W-1:0] heard_at [CHANNELS] = '{default: '0};
    logic [TIME_W-1:0] online_at [CHANNELS] = '{default: '0};
    logic [TIME_W-1:0] lost_at [CHANNELS] = '{default: '0};
    logic [MASK_W-1:0] lost_bits = '1;
    logic [MASK_W-1:0] enabled_bits = '1;

    out_item_t pending_status [$];
    int        error_count = 0;
    int        cycle_count = 0;
    logic      idle_enabled = 1'b1;
    int        hold_requests = 0;
    int        holds_served = 0;

    multi_channel_liveness_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Works out the status that the monitor reports after one item.
    function automatic out_item_t predict_status(input in_item_t item);
        out_item_t         status;
        logic [MASK_W-1:0] ch_bit;
        logic [TIME_W-1:0] since_online;
        logic [TIME_W-1:0] silence;
        logic              in_range;
        in_range = int'(item.channel) < CHANNELS;
        ch_bit = 8'd1 << item.channel;
        case (item.command)
            CMD_TICK: begin
                tick_now = tick_now + 1;
            end
            CMD_HEARD: begin
                if (in_range) begin
                    heard_at[item.channel] = tick_now;
                    if ((lost_bits & ch_bit) != 0) begin
                        lost_bits = lost_bits & ~ch_bit;
                        online_at[item.channel] = tick_now;
                    end
                end
            end
            CMD_ENABLE: begin
                if (in_range) begin
                    if (item.enable_value)
                        enabled_bits = enabled_bits | ch_bit;
                    else
                        enabled_bits = enabled_bits & ~ch_bit;
                end
            end
            default: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (enabled_bits[c]) begin
                        since_online = tick_now - online_at[c];
                        silence = tick_now - heard_at[c];
                        if (since_online < {24'd0, holdoff_reg[c*BYTE_W +: BYTE_W]}) begin
                            lost_bits[c] = 1'b0;
                        end else if (silence > {24'd0, limit_reg[c*BYTE_W +: BYTE_W]}) begin
                            // A channel already lost keeps its original loss time.
                            if (!lost_bits[c]) begin
                                lost_bits[c] = 1'b1;
                                lost_at[c] = tick_now;
                            end
                        end else begin
                            lost_bits[c] = 1'b0;
                        end
                    end
                end
            end
        endcase
        status.lost_mask = lost_bits;
        status.channel_lost_time = in_range ? lost_at[item.channel] : '0;
        return status;
    endfunction

    function automatic in_item_t make_cmd(input cmd_t command, input int ch, input logic en);
        in_item_t item;
        item.command = command;
        item.channel = ch[CHAN_W-1:0];
        item.enable_value = en;
        return item;
    endfunction

    // Mostly ticks, heards from a chosen set of channels and scans; the rest is noise.
    function automatic in_item_t random_item(input logic [MASK_W-1:0] talking);
        in_item_t item;
        int       pick;
        pick = $urandom_range(99);
        item.channel = CHAN_W'($urandom_range(7));
        item.enable_value = 1'($urandom_range(1));
        if (pick < 40) begin
            item.command = CMD_TICK;
        end else if (pick < 66) begin
            item.command = CMD_HEARD;
            if (talking != 0 && $urandom_range(4) != 0) begin
                while (!talking[item.channel])
                    item.channel = CHAN_W'($urandom_range(7));
            end
        end else if (pick < 82) begin
            item.command = CMD_SCAN;
        end else if (pick < 90) begin
            item.command = CMD_ENABLE;
            item.enable_value = ($urandom_range(3) != 0);
        end else begin
            item.command = cmd_t'($urandom_range(3));
        end
        return item;
    endfunction

    function automatic logic [CFG_W-1:0] random_bytes(input int hi);
        logic [CFG_W-1:0] value;
        for (int c = 0; c < 8; c++)
            value[c*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(hi));
        return value;
    endfunction

    task automatic send_item(input in_item_t item);
        @(negedge aclk);
        while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = item;
        do @(posedge aclk); while (!s_ready);
        pending_status.push_back(predict_status(item));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_OFFLINE_LIMITS)
            limit_reg = value;
        else
            holdoff_reg = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random(input int count, input logic [MASK_W-1:0] talking);
        for (int n = 0; n < count; n++)
            send_item(random_item(talking));
    endtask

    task automatic test_directed();
        // At reset every channel is lost but none has been silent yet.
        send_item(make_cmd(CMD_SCAN, 0, 1'b0));
        write_register(CFG_OFFLINE_LIMITS, '0);
        write_register(CFG_ONLINE_HOLDOFFS, 64'h0000_0000_0000_FF00);
        send_item(make_cmd(CMD_TICK, 7, 1'b1));
        send_item(make_cmd(CMD_HEARD, 0, 1'b0));
        send_item(make_cmd(CMD_ENABLE, 7, 1'b0));
        send_item(make_cmd(CMD_SCAN, 3, 1'b0));
        send_item(make_cmd(CMD_TICK, 3, 1'b0));
        send_item(make_cmd(CMD_HEARD, 1, 1'b1));
        send_item(make_cmd(CMD_SCAN, 3, 1'b0));
        send_item(make_cmd(CMD_HEARD, 2, 1'b0));
        send_item(make_cmd(CMD_HEARD, 7, 1'b0));
        send_item(make_cmd(CMD_TICK, 2, 1'b0));
        send_item(make_cmd(CMD_SCAN, 2, 1'b0));
        send_item(make_cmd(CMD_ENABLE, 7, 1'b1));
        send_item(make_cmd(CMD_TICK, 7, 1'b0));
        send_item(make_cmd(CMD_SCAN, 7, 1'b0));
        send_item(make_cmd(CMD_ENABLE, 0, 1'b0));
        send_item(make_cmd(CMD_TICK, 0, 1'b0));
        send_item(make_cmd(CMD_SCAN, 0, 1'b1));
        send_item(make_cmd(CMD_ENABLE, 0, 1'b1));
        send_item(make_cmd(CMD_TICK, 4, 1'b0));
        send_item(make_cmd(CMD_HEARD, 5, 1'b1));
        send_item(make_cmd(CMD_TICK, 6, 1'b1));
    endtask

    task automatic test_limit_extremes();
        // Zero timeouts under the longest holdoff, then the longest timeouts with no holdoff.
        write_register(CFG_OFFLINE_LIMITS, '0);
        write_register(CFG_ONLINE_HOLDOFFS, '1);
        send_random(120, MASK_W'($urandom_range(255)));
        write_register(CFG_OFFLINE_LIMITS, '1);
        write_register(CFG_ONLINE_HOLDOFFS, '0);
        send_random(120, MASK_W'($urandom_range(255)));
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++) begin
            write_register(CFG_OFFLINE_LIMITS, random_bytes(24));
            write_register(CFG_ONLINE_HOLDOFFS, (phase == 0) ? '0 : random_bytes(12));
            send_random(130, MASK_W'($urandom_range(255)));
        end
    endtask

    task automatic test_no_idling();
        write_register(CFG_OFFLINE_LIMITS, random_bytes(16));
        write_register(CFG_ONLINE_HOLDOFFS, random_bytes(8));
        idle_enabled = 1'b0;
        send_random(120, MASK_W'($urandom_range(255)));
        idle_enabled = 1'b1;
    endtask

    task automatic test_receiver_hold();
        write_register(CFG_OFFLINE_LIMITS, LIMITS_RESET);
        write_register(CFG_ONLINE_HOLDOFFS, HOLDOFFS_RESET);
        // The sender keeps offering items while the receiver holds off, so the block fills.
        hold_requests++;
        send_random(60, MASK_W'($urandom_range(255)));
    endtask

    task automatic test_sender_pause();
        write_register(CFG_OFFLINE_LIMITS, random_bytes(20));
        send_random(60, 8'h0F);
        wait_idle();
        send_random(60, 8'hF0);
    endtask

    // Receiver side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready = !idle_enabled || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, m_data);
                error_count++;
            end else begin
                if (m_data.lost_mask !== pending_status[0].lost_mask) begin
                    $display("%0t: lost_mask mismatch, expected %h, actual %h", $time,
                             pending_status[0].lost_mask, m_data.lost_mask);
                    error_count++;
                end
                if (m_data.channel_lost_time !== pending_status[0].channel_lost_time) begin
                    $display("%0t: channel_lost_time mismatch, expected %h, actual %h", $time,
                             pending_status[0].channel_lost_time, m_data.channel_lost_time);
                    error_count++;
                end
                void'(pending_status.pop_front());
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_limit_extremes();
        test_random_settings();
        test_no_idling();
        test_receiver_hold();
        test_sender_pause();
        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
